@@ src/sxd_pkg.sv @@
// Shared types and codes for the sixel stream run decoder.
// Depends on nothing; every module of the block imports it.
package sxd_pkg;

   // Result kinds.
   localparam logic [1:0] KIND_RUN   = 2'd0;
   localparam logic [1:0] KIND_ERROR = 2'd1;
   localparam logic [1:0] KIND_TERM  = 2'd2;

   // Configuration register indexes and port widths.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 13;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_COLOR  = 2'd2;

   // One input beat.
   typedef struct packed {
      logic       req_type;
      logic [7:0] data_byte;
   } sxd_req_type;

   // One result beat.
   typedef struct packed {
      logic [1:0]  kind;
      logic [11:0] row;
      logic [11:0] column;
      logic [12:0] run_length;
      logic [7:0]  color;
      logic        last;
   } sxd_rsp_type;

   // One job handed from the parser to the run generator. Runs are emitted
   // for the bits of run_mask, lowest first; err adds a closing abort or terminator beat.
   typedef struct packed {
      logic [5:0]  run_mask;
      logic        err;
      logic [1:0]  err_kind;
      logic [15:0] row;
      logic [15:0] col;
      logic [15:0] len;
      logic [7:0]  color;
   } sxd_job_type;

endpackage

@@ src/sixel_stream_run_decoder.sv @@
// Top level of the sixel stream run decoder: parser, job queue, run generator.
// Depends on sxd_pkg, sxd_front, sxd_queue and sxd_back.
//
//   Channel   Direction  Handshake              Beat
//   req_      in         req_valid / req_stall  sxd_req_type (frame start or byte)
//   rsp_      out        rsp_valid / rsp_stall  sxd_rsp_type (run, abort, end)
//   csr_      in         csr_valid / csr_ready  csr_index, csr_data (13 bits)
//
// The parser takes one beat per cycle while the job queue has room.
// The run generator loads a job and then emits its result beats while rsp_stall
// allows; it takes the next job only after it has issued the last beat of the current one.
// Bytes that cause no result push no job and never reach the run generator.
// Reset is synchronous and clears all control state; there is no clearing pass.
// rsp_stall holds the output register; the queue then fills and raises req_stall.
module sixel_stream_run_decoder
   import sxd_pkg::*;
#(
   parameter int MAX_DIM      = 4096,
   parameter int PALETTE_SIZE = 256,
   parameter int QUEUE_DEPTH  = 2
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  sxd_req_type            req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output sxd_rsp_type            rsp_payload,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   logic        q_push;
   logic        q_pop;
   logic        q_full;
   logic        q_empty;
   sxd_job_type push_job;
   sxd_job_type pop_job;

   sxd_front #(
      .MAX_DIM      (MAX_DIM),
      .PALETTE_SIZE (PALETTE_SIZE)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_job       (push_job)
   );

   sxd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .pop      (q_pop),
      .pop_job  (pop_job),
      .full     (q_full),
      .empty    (q_empty)
   );

   sxd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_empty     (q_empty),
      .q_job       (pop_job),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // The parser never pushes into a full queue.
   assert property (@(posedge clock) disable iff (reset) q_push |-> !q_full)
      else $error("job pushed into a full queue");

   // After an aborting job the parser is stopped and pushes nothing next cycle.
   assert property (@(posedge clock) disable iff (reset) (q_push && push_job.err) |=> !q_push)
      else $error("job pushed right after an abort");

   // Abort and terminator beats close their byte and carry no run.
   assert property (@(posedge clock) disable iff (reset)
                    (rsp_valid && rsp_payload.kind != KIND_RUN) |->
                    (rsp_payload.last && rsp_payload.run_length == 13'd0))
      else $error("abort beat without last or with a run length");

endmodule

@@ src/sxd_front.sv @@
// Parser front end: configuration registers, token parsing and pen state.
// Depends on sxd_pkg; pushes one job per result-producing byte into the queue.
module sxd_front
   import sxd_pkg::*;
#(
   parameter int MAX_DIM      = 4096,
   parameter int PALETTE_SIZE = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  sxd_req_type            req_payload,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   input  logic                   q_full,
   output logic                   q_push,
   output sxd_job_type            q_job
);

   localparam logic [16:0] DIM_LIM     = 17'(MAX_DIM);
   localparam int          COLOR_LIM_I = (PALETTE_SIZE - 1 > 255) ? 255 : PALETTE_SIZE - 1;
   localparam logic [7:0]  COLOR_LIM   = 8'(COLOR_LIM_I);

   localparam logic [1:0] MODE_IDLE   = 2'd0;
   localparam logic [1:0] MODE_COLOR  = 2'd1;
   localparam logic [1:0] MODE_REPEAT = 2'd2;

   localparam logic [7:0] CH_CAN    = 8'h18;
   localparam logic [7:0] CH_SUB    = 8'h1a;
   localparam logic [7:0] CH_ESC    = 8'h1b;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_BANG   = 8'h21;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_MINUS  = 8'h2d;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_SEMI   = 8'h3b;
   localparam logic [7:0] CH_FIRST  = 8'h3f;
   localparam logic [7:0] CH_LAST   = 8'h7e;
   localparam logic [7:0] CH_BSLASH = 8'h5c;

   logic [12:0] width_ff, width_in;
   logic [12:0] height_ff, height_in;
   logic [7:0]  start_color_ff, start_color_in;
   logic [15:0] col_ff, col_in;
   logic [15:0] row_ff, row_in;
   logic [15:0] rep_ff, rep_in;
   logic [7:0]  color_ff, color_in;
   logic [15:0] acc_ff, acc_in;
   logic [1:0]  mode_ff, mode_in;
   logic        esc_ff, esc_in;
   logic        stopped_ff, stopped_in;

   logic        accept;
   logic [7:0]  b;
   logic        is_digit;
   logic [19:0] acc_next;
   logic [15:0] acc_sat;
   logic [7:0]  acc_color;
   logic [15:0] rep_cur;
   logic [7:0]  color_cur;
   logic [16:0] w_lim;
   logic [16:0] h_lim;
   logic [16:0] col_sum;
   logic [16:0] row_band;
   logic        col_fail;
   logic [5:0]  row_fail;
   logic [5:0]  bits;
   logic [5:0]  fail_bits;
   logic [5:0]  fail_low;
   logic        push_v;
   logic [5:0]  mask_v;
   logic        err_v;
   logic [1:0]  err_kind_v;
   logic        go;

   assign accept    = req_valid && !req_stall;
   assign req_stall = q_full;
   assign csr_ready = 1'b1;
   assign b         = req_payload.data_byte;

   // Number accumulation saturates at 16 bits; times ten is a shift and add.
   assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
   assign acc_next = 20'({acc_ff, 3'b000}) + 20'({acc_ff, 1'b0}) + 20'(b[3:0]);
   assign acc_sat  = (acc_next > 20'h0ffff) ? 16'hffff : acc_next[15:0];

   // Values in force for the token once a pending number completes on this byte.
   assign acc_color = (acc_ff > {8'd0, COLOR_LIM}) ? COLOR_LIM : acc_ff[7:0];
   assign rep_cur   = (mode_ff == MODE_REPEAT && !is_digit) ?
                      ((acc_ff == 16'd0) ? 16'd1 : acc_ff) : rep_ff;
   assign color_cur = (mode_ff == MODE_COLOR && !is_digit) ? acc_color : color_ff;

   // Bounds of the raster byte: one column test for the byte and one row test per bit.
   assign w_lim    = ({4'd0, width_ff} > DIM_LIM) ? DIM_LIM : {4'd0, width_ff};
   assign h_lim    = ({4'd0, height_ff} > DIM_LIM) ? DIM_LIM : {4'd0, height_ff};
   assign col_sum  = {1'b0, col_ff} + {1'b0, rep_cur};
   assign row_band = {1'b0, row_ff} + 17'd6;
   assign col_fail = col_sum > w_lim;
   assign bits     = 6'(b - CH_FIRST);

   always_comb begin
      for (int i = 0; i < 6; i++) begin
         row_fail[i] = ({1'b0, row_ff} + 17'(i)) >= h_lim;
      end
   end

   // The first failing set bit ends the byte; runs below it still go out.
   assign fail_bits = bits & (col_fail ? 6'h3f : row_fail);
   assign fail_low  = fail_bits & (~fail_bits + 6'd1);

   // Token parser and pen state update.
   always_comb begin
      col_in     = col_ff;
      row_in     = row_ff;
      rep_in     = rep_ff;
      color_in   = color_ff;
      acc_in     = acc_ff;
      mode_in    = mode_ff;
      esc_in     = esc_ff;
      stopped_in = stopped_ff;
      push_v     = 1'b0;
      mask_v     = 6'd0;
      err_v      = 1'b0;
      err_kind_v = KIND_ERROR;
      go         = 1'b1;
      if (accept) begin
         if (req_payload.req_type) begin
            col_in     = 16'd0;
            row_in     = 16'd0;
            rep_in     = 16'd1;
            color_in   = (start_color_ff > COLOR_LIM) ? COLOR_LIM : start_color_ff;
            acc_in     = 16'd0;
            mode_in    = MODE_IDLE;
            esc_in     = 1'b0;
            stopped_in = 1'b0;
         end else if (!stopped_ff) begin
            // An escape is dropped unless a backslash completes the terminator.
            if (esc_ff) begin
               esc_in = 1'b0;
               if (b == CH_BSLASH) begin
                  push_v     = 1'b1;
                  err_v      = 1'b1;
                  err_kind_v = KIND_TERM;
                  stopped_in = 1'b1;
                  go         = 1'b0;
               end
            end
            // A pending number takes digits; any other byte completes it.
            if (go && mode_ff != MODE_IDLE) begin
               if (is_digit) begin
                  acc_in = acc_sat;
                  go     = 1'b0;
               end else begin
                  mode_in = MODE_IDLE;
                  acc_in  = 16'd0;
                  if (mode_ff == MODE_COLOR) begin
                     if (b == CH_SEMI) begin
                        push_v     = 1'b1;
                        err_v      = 1'b1;
                        stopped_in = 1'b1;
                        go         = 1'b0;
                     end else begin
                        color_in = color_cur;
                     end
                  end else begin
                     rep_in = rep_cur;
                  end
               end
            end
            if (go) begin
               if (b >= CH_FIRST && b <= CH_LAST) begin
                  if (fail_bits != 6'd0) begin
                     push_v     = 1'b1;
                     mask_v     = bits & (fail_low - 6'd1);
                     err_v      = 1'b1;
                     stopped_in = 1'b1;
                  end else begin
                     push_v = bits != 6'd0;
                     mask_v = bits;
                     col_in = col_sum[16] ? 16'hffff : col_sum[15:0];
                     rep_in = 16'd1;
                  end
               end else begin
                  case (b)
                     CH_HASH: begin
                        mode_in = MODE_COLOR;
                        acc_in  = 16'd0;
                     end
                     CH_BANG: begin
                        mode_in = MODE_REPEAT;
                        acc_in  = 16'd0;
                     end
                     CH_DOLLAR: begin
                        col_in = 16'd0;
                     end
                     CH_MINUS: begin
                        col_in = 16'd0;
                        row_in = row_band[16] ? 16'hffff : row_band[15:0];
                     end
                     CH_CAN, CH_SUB, CH_QUOTE: begin
                        push_v     = 1'b1;
                        err_v      = 1'b1;
                        stopped_in = 1'b1;
                     end
                     CH_ESC: begin
                        esc_in = 1'b1;
                     end
                     default: begin
                     end
                  endcase
               end
            end
         end
      end
   end

   // Job handed to the run generator.
   assign q_push         = push_v;
   assign q_job.run_mask = mask_v;
   assign q_job.err      = err_v;
   assign q_job.err_kind = err_kind_v;
   assign q_job.row      = row_ff;
   assign q_job.col      = col_ff;
   assign q_job.len      = rep_cur;
   assign q_job.color    = color_cur;

   // Configuration writes.
   always_comb begin
      width_in       = width_ff;
      height_in      = height_ff;
      start_color_in = start_color_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  width_in       = csr_data;
            CSR_IMAGE_HEIGHT: height_in      = csr_data;
            CSR_START_COLOR:  start_color_in = csr_data[7:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff       <= 13'd4096;
         height_ff      <= 13'd4096;
         start_color_ff <= 8'd0;
         col_ff         <= 16'd0;
         row_ff         <= 16'd0;
         rep_ff         <= 16'd1;
         color_ff       <= 8'd0;
         acc_ff         <= 16'd0;
         mode_ff        <= MODE_IDLE;
         esc_ff         <= 1'b0;
         stopped_ff     <= 1'b0;
      end else begin
         width_ff       <= width_in;
         height_ff      <= height_in;
         start_color_ff <= start_color_in;
         col_ff         <= col_in;
         row_ff         <= row_in;
         rep_ff         <= rep_in;
         color_ff       <= color_in;
         acc_ff         <= acc_in;
         mode_ff        <= mode_in;
         esc_ff         <= esc_in;
         stopped_ff     <= stopped_in;
      end
   end

endmodule

@@ src/sxd_queue.sv @@
// Short job queue between the parser and the run generator.
// Depends on sxd_pkg for the job type.
module sxd_queue
   import sxd_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  sxd_job_type push_job,
   input  logic        pop,
   output sxd_job_type pop_job,
   output logic        full,
   output logic        empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   sxd_job_type      slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full    = count_ff == CNT_FULL;
   assign empty   = count_ff == '0;
   assign pop_job = slots_ff[rd_ptr_ff];

   // Pointers wrap at the depth; the count tracks occupancy.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Slot storage carries no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

@@ src/sxd_back.sv @@
// Run generator: expands each queued job into result beats, one per cycle when not stalled.
// Depends on sxd_pkg; drives the registered result channel.
module sxd_back
   import sxd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        q_empty,
   input  sxd_job_type q_job,
   output logic        q_pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output sxd_rsp_type rsp_payload
);

   logic        act_ff, act_in;
   sxd_job_type job_ff, job_in;
   logic        rsp_valid_ff, rsp_valid_in;
   sxd_rsp_type rsp_ff, rsp_in;

   logic        out_free;
   logic [2:0]  idx;
   logic [5:0]  rest;

   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign q_pop       = !act_ff && !q_empty;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Lowest set bit of the remaining mask picks the row of the next run.
   always_comb begin
      idx = 3'd0;
      for (int i = 5; i >= 0; i--) begin
         if (job_ff.run_mask[i]) begin
            idx = 3'(i);
         end
      end
   end

   assign rest = job_ff.run_mask & (job_ff.run_mask - 6'd1);

   // Load a job, then emit its runs and the closing abort or terminator beat if any.
   always_comb begin
      act_in       = act_ff;
      job_in       = job_ff;
      rsp_valid_in = out_free ? 1'b0 : rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (q_pop) begin
         act_in = 1'b1;
         job_in = q_job;
      end else if (act_ff && out_free) begin
         rsp_valid_in = 1'b1;
         if (job_ff.run_mask != 6'd0) begin
            rsp_in.kind       = KIND_RUN;
            rsp_in.row        = job_ff.row[11:0] + {9'd0, idx};
            rsp_in.column     = job_ff.col[11:0];
            rsp_in.run_length = job_ff.len[12:0];
            rsp_in.color      = job_ff.color;
            rsp_in.last       = (rest == 6'd0) && !job_ff.err;
            job_in.run_mask   = rest;
            if (rest == 6'd0 && !job_ff.err) begin
               act_in = 1'b0;
            end
         end else begin
            rsp_in.kind       = job_ff.err_kind;
            rsp_in.row        = 12'd0;
            rsp_in.column     = 12'd0;
            rsp_in.run_length = 13'd0;
            rsp_in.color      = 8'd0;
            rsp_in.last       = 1'b1;
            act_in            = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         act_ff       <= act_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      job_ff <= job_in;
      rsp_ff <= rsp_in;
   end

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for the sixel stream run decoder.
// Depends on sxd_pkg and sixel_stream_run_decoder; predicts every result beat in-line.
// Directed token checks, image-size extremes, back-pressure and random frames.
module tb_top;
   import sxd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // Request types and the byte codes the decoder reacts to.
   localparam logic REQ_BYTE  = 1'b0;
   localparam logic REQ_FRAME = 1'b1;
   localparam logic [7:0] CH_CAN       = 8'h18;
   localparam logic [7:0] CH_SUB       = 8'h1A;
   localparam logic [7:0] CH_ESC       = 8'h1B;
   localparam logic [7:0] CH_BANG      = 8'h21;
   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_HASH      = 8'h23;
   localparam logic [7:0] CH_DOLLAR    = 8'h24;
   localparam logic [7:0] CH_MINUS     = 8'h2D;
   localparam logic [7:0] CH_ZERO      = 8'h30;
   localparam logic [7:0] CH_NINE      = 8'h39;
   localparam logic [7:0] CH_SEMI      = 8'h3B;
   localparam logic [7:0] CH_RASTER_LO = 8'h3F;
   localparam logic [7:0] CH_RASTER_HI = 8'h7E;
   localparam logic [7:0] CH_BSLASH    = 8'h5C;
   localparam logic [7:0] CH_ONE_BIT   = 8'h40;
   localparam logic [7:0] CH_BIT_ONE   = 8'h41;
   localparam logic [7:0] CH_ALL_BITS  = 8'h7E;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   // Block limits and testbench timing.
   localparam int unsigned IMG_LIMIT     = 4096;
   localparam int unsigned COLOR_LIMIT   = 255;
   localparam int unsigned SETTLE_CYCLES = 16;
   localparam int unsigned LONG_HOLD     = 300;
   localparam int unsigned STUCK_LIMIT   = 2000;

   typedef enum logic [1:0] {NUM_NONE, NUM_COLOR, NUM_REPEAT} num_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   sxd_req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   sxd_rsp_type rsp_payload;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   sixel_stream_run_decoder DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always #10 clock = ~clock;

   // Decoder state as the testbench sees it.
   logic [12:0]  cfg_width;
   logic [12:0]  cfg_height;
   logic [7:0]   cfg_start;
   logic [15:0]  pen_col;
   logic [15:0]  pen_row;
   logic [15:0]  run_repeat;
   logic [7:0]   pen_color;
   logic [15:0]  num_acc;
   num_mode_type num_mode;
   logic         esc_seen;
   logic         halted;

   sxd_rsp_type due_results[$];

   int unsigned beats_sent = 0;
   int unsigned frames_started = 0;
   int unsigned runs_checked = 0;
   int unsigned aborts_checked = 0;
   int unsigned ends_checked = 0;
   int unsigned check_errors = 0;
   int unsigned stuck_cycles = 0;
   int unsigned hold_requests = 0;
   int unsigned holds_served = 0;
   bit          steady_flow = 1'b0;

   function automatic logic [15:0] sat16(int unsigned v);
      return (v > 32'hFFFF) ? 16'hFFFF : v[15:0];
   endfunction

   function automatic logic [7:0] clamp_color(logic [15:0] v);
      return (v > COLOR_LIMIT) ? 8'(COLOR_LIMIT) : v[7:0];
   endfunction

   function automatic void begin_frame();
      pen_col    = '0;
      pen_row    = '0;
      run_repeat = 16'd1;
      pen_color  = clamp_color({8'd0, cfg_start});
      num_acc    = '0;
      num_mode   = NUM_NONE;
      esc_seen   = 1'b0;
      halted     = 1'b0;
   endfunction

   // An abort or terminator closes the frame with one beat that is zero but for kind and last.
   function automatic void halt_frame(logic [1:0] kind);
      sxd_rsp_type beat;
      beat      = '0;
      beat.kind = kind;
      beat.last = 1'b1;
      halted    = 1'b1;
      due_results.push_back(beat);
   endfunction

   function automatic void apply_csr(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      case (idx)
         CSR_IMAGE_WIDTH: cfg_width = val;
         CSR_IMAGE_HEIGHT: cfg_height = val;
         CSR_START_COLOR: cfg_start = val[7:0];
         default: ;
      endcase
   endfunction

   // Works out the result beats that one accepted input beat causes.
   function automatic void decode_beat(sxd_req_type beat);
      logic [7:0]  b;
      int unsigned bits;
      int unsigned lim_w;
      int unsigned lim_h;
      int unsigned r;
      int          n;
      int          i;
      sxd_rsp_type run;
      b = beat.data_byte;
      if (beat.req_type == REQ_FRAME) begin
         begin_frame();
         return;
      end
      if (halted) return;
      // An escape only matters when a backslash follows it.
      if (esc_seen) begin
         esc_seen = 1'b0;
         if (b == CH_BSLASH) begin
            halt_frame(KIND_TERM);
            return;
         end
      end
      // A pending number takes digits; anything else completes it.
      if (num_mode != NUM_NONE) begin
         if (b >= CH_ZERO && b <= CH_NINE) begin
            num_acc = sat16(32'(num_acc) * 10 + 32'(b - CH_ZERO));
            return;
         end
         if (num_mode == NUM_COLOR) begin
            num_mode = NUM_NONE;
            if (b == CH_SEMI) begin
               halt_frame(KIND_ERROR);
               return;
            end
            pen_color = clamp_color(num_acc);
         end else begin
            num_mode   = NUM_NONE;
            run_repeat = (num_acc == 0) ? 16'd1 : num_acc;
         end
         num_acc = '0;
      end
      // Raster byte: one run per set bit, lowest bit first, up to the first bit out of bounds.
      if (b >= CH_RASTER_LO && b <= CH_RASTER_HI) begin
         bits  = 32'(b - CH_RASTER_LO);
         lim_w = (cfg_width > IMG_LIMIT) ? IMG_LIMIT : 32'(cfg_width);
         lim_h = (cfg_height > IMG_LIMIT) ? IMG_LIMIT : 32'(cfg_height);
         n     = 0;
         for (i = 0; i < 6; i++) begin
            if (((bits >> i) & 1) != 0) begin
               r = 32'(pen_row) + i;
               if (32'(pen_col) + 32'(run_repeat) > lim_w || r >= lim_h) begin
                  halt_frame(KIND_ERROR);
                  return;
               end
               run            = '0;
               run.kind       = KIND_RUN;
               run.row        = 12'(r);
               run.column     = pen_col[11:0];
               run.run_length = run_repeat[12:0];
               run.color      = pen_color;
               due_results.push_back(run);
               n++;
            end
         end
         if (n > 0) due_results[$].last = 1'b1;
         pen_col    = sat16(32'(pen_col) + 32'(run_repeat));
         run_repeat = 16'd1;
         return;
      end
      case (b)
         CH_HASH: begin
            num_mode = NUM_COLOR;
            num_acc  = '0;
         end
         CH_BANG: begin
            num_mode = NUM_REPEAT;
            num_acc  = '0;
         end
         CH_DOLLAR: pen_col = '0;
         CH_MINUS: begin
            pen_col = '0;
            pen_row = sat16(32'(pen_row) + 6);
         end
         CH_CAN, CH_SUB, CH_QUOTE: halt_frame(KIND_ERROR);
         CH_ESC: esc_seen = 1'b1;
         default: ;
      endcase
   endfunction

   // Mostly short idle stretches, now and then a long one.
   function automatic int unsigned idle_length();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) return $urandom_range(1, 3);
      if (pick < 95) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Offers one beat, waits for it to be taken and then maybe idles.
   task automatic send_beat(logic kind, logic [7:0] data);
      sxd_req_type beat;
      int unsigned gap;
      beat.req_type  = kind;
      beat.data_byte = data;
      req_valid   <= 1'b1;
      req_payload <= beat;
      do @(posedge clock); while (req_stall);
      decode_beat(beat);
      beats_sent++;
      if (kind == REQ_FRAME) frames_started++;
      gap = (!steady_flow && $urandom_range(0, 99) < 35) ? idle_length() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_byte(logic [7:0] data);
      send_beat(REQ_BYTE, data);
   endtask

   task automatic send_frame_start();
      send_beat(REQ_FRAME, 8'($urandom_range(0, 255)));
   endtask

   // Sends the decimal digits of a value.
   task automatic send_number(int unsigned value);
      string digits;
      int    k;
      digits = $sformatf("%0d", value);
      for (k = 0; k < digits.len(); k++) send_byte(digits[k]);
   endtask

   // One register write; valid drops again before the next write.
   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      apply_csr(idx, val);
      @(posedge clock);
   endtask

   // Stops offering beats, waits for every due result and lets the pipe empty.
   task automatic settle_block();
      req_valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Random frames: each opens with a frame start and runs until its length, an abort,
   // a terminator or the beat budget.
   task automatic random_frames(int unsigned count, int unsigned max_rep);
      int unsigned first;
      int unsigned frame_len;
      int unsigned j;
      int unsigned pick;
      first = beats_sent;
      while (beats_sent - first < count) begin
         send_frame_start();
         frame_len = $urandom_range(4, 20);
         for (j = 0; j < frame_len && !halted && beats_sent - first < count; j++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
               send_byte(8'($urandom_range(CH_RASTER_LO, CH_RASTER_HI)));
            end else if (pick < 55) begin
               send_byte(CH_HASH);
               if ($urandom_range(0, 9) != 0)
                  send_number(($urandom_range(0, 19) == 0) ? 70000 : $urandom_range(0, 300));
            end else if (pick < 65) begin
               send_byte(CH_BANG);
               if ($urandom_range(0, 9) != 0)
                  send_number(($urandom_range(0, 29) == 0) ? 99999 : $urandom_range(0, max_rep));
            end else if (pick < 72) begin
               send_byte(CH_DOLLAR);
            end else if (pick < 78) begin
               send_byte(CH_MINUS);
            end else if (pick < 80) begin
               send_byte(CH_ESC);
               send_byte(($urandom_range(0, 1) != 0) ? CH_BSLASH : 8'($urandom_range(0, 255)));
            end else if (pick < 83) begin
               case ($urandom_range(0, 3))
                  0: send_byte(CH_CAN);
                  1: send_byte(CH_SUB);
                  2: send_byte(CH_QUOTE);
                  default: begin
                     send_byte(CH_HASH);
                     send_number($urandom_range(0, 255));
                     send_byte(CH_SEMI);
                  end
               endcase
            end else begin
               send_byte(8'($urandom_range(0, 255)));
            end
         end
      end
   endtask

   // Every token with the default image size, then each abort and the terminator.
   task automatic test_token_basics();
      send_frame_start();
      send_byte(CH_HASH);
      send_number(300);
      send_byte(CH_ALL_BITS);
      send_byte(CH_BANG);
      send_number(0);
      send_byte(CH_DOLLAR);
      send_byte(CH_MINUS);
      send_byte(CH_ESC);
      send_byte(CH_BIT_ONE);
      send_byte(8'h35);
      send_byte(CH_SEMI);
      send_byte(8'hFF);
      send_byte(CH_CAN);
      send_byte(CH_BIT_ONE);
      send_frame_start();
      send_byte(CH_HASH);
      send_number(7);
      send_byte(CH_SEMI);
      send_frame_start();
      send_byte(CH_SUB);
      send_frame_start();
      send_byte(CH_QUOTE);
      send_frame_start();
      send_byte(CH_ESC);
      send_byte(CH_BSLASH);
   endtask

   task automatic test_random_default();
      steady_flow = 1'b1;
      random_frames(10, 40);
      steady_flow = 1'b0;
      random_frames(10, 40);
   endtask

   // A tiny image so that runs hit both bounds often.
   task automatic test_small_image();
      settle_block();
      write_csr(CSR_IMAGE_WIDTH, 13'd8);
      write_csr(CSR_IMAGE_HEIGHT, 13'd12);
      write_csr(CSR_START_COLOR, 13'd255);
      write_csr(CSR_UNUSED, 13'h1FFF);
      random_frames(10, 6);
   endtask

   // Zero, one-pixel and above-limit image sizes, plus saturating columns.
   task automatic test_dimension_extremes();
      settle_block();
      write_csr(CSR_IMAGE_WIDTH, 13'd0);
      write_csr(CSR_IMAGE_HEIGHT, 13'd4096);
      send_frame_start();
      send_byte(CH_RASTER_LO);
      send_byte(CH_ALL_BITS);
      settle_block();
      write_csr(CSR_IMAGE_WIDTH, 13'd1);
      write_csr(CSR_IMAGE_HEIGHT, 13'd1);
      send_frame_start();
      send_byte(CH_ONE_BIT);
      send_byte(CH_DOLLAR);
      send_byte(CH_BIT_ONE);
      settle_block();
      write_csr(CSR_IMAGE_WIDTH, 13'h1FFF);
      write_csr(CSR_IMAGE_HEIGHT, 13'h1FFF);
      write_csr(CSR_START_COLOR, 13'd0);
      send_frame_start();
      send_byte(CH_BANG);
      send_number(4096);
      send_byte(CH_ONE_BIT);
      send_byte(CH_ONE_BIT);
      send_frame_start();
      send_byte(CH_BANG);
      send_number(99999);
      send_byte(CH_RASTER_LO);
      send_byte(CH_RASTER_LO);
      send_byte(CH_ONE_BIT);
   endtask

   // The receiver holds off while six-run bytes keep coming, then the sender waits.
   task automatic test_backpressure();
      int k;
      settle_block();
      write_csr(CSR_IMAGE_WIDTH, 13'd4096);
      write_csr(CSR_IMAGE_HEIGHT, 13'd4096);
      steady_flow = 1'b1;
      hold_requests++;
      send_frame_start();
      for (k = 0; k < 16; k++) send_byte(CH_ALL_BITS);
      steady_flow = 1'b0;
      settle_block();
   endtask

   task automatic test_random_mixed();
      int k;
      for (k = 0; k < 2; k++) begin
         settle_block();
         write_csr(CSR_IMAGE_WIDTH,
                   ($urandom_range(0, 4) == 0) ? 13'($urandom_range(4097, 8191))
                                               : 13'($urandom_range(16, 4096)));
         write_csr(CSR_IMAGE_HEIGHT, 13'($urandom_range(6, 64)));
         write_csr(CSR_START_COLOR, 13'($urandom_range(0, 255)));
         random_frames(5, 24);
      end
   endtask

   // Result checking: each beat taken is compared with the oldest due result.
   task automatic compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         check_errors++;
      end
   endtask

   always @(posedge clock) begin
      sxd_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_results.size() == 0) begin
            $error("result beat with nothing due: kind %0d", rsp_payload.kind);
            check_errors++;
         end else begin
            want = due_results.pop_front();
            compare_field("kind", want.kind, rsp_payload.kind);
            compare_field("row", want.row, rsp_payload.row);
            compare_field("column", want.column, rsp_payload.column);
            compare_field("run_length", want.run_length, rsp_payload.run_length);
            compare_field("color", want.color, rsp_payload.color);
            compare_field("last", want.last, rsp_payload.last);
            case (want.kind)
               KIND_RUN: runs_checked++;
               KIND_ERROR: aborts_checked++;
               default: ends_checked++;
            endcase
         end
      end
   end

   // Receiver stall pattern: random bursts, and a long hold whenever one is requested.
   int unsigned stall_left = 0;
   logic        stall_level = 1'b0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (hold_requests != holds_served) begin
            holds_served = hold_requests;
            stall_level  = 1'b1;
            stall_left   = LONG_HOLD;
         end else if (stall_left == 0) begin
            if (steady_flow || $urandom_range(0, 99) >= 35) begin
               stall_level = 1'b0;
               stall_left  = $urandom_range(1, 12);
            end else begin
               stall_level = 1'b1;
               stall_left  = idle_length();
            end
         end
         stall_left--;
         rsp_stall <= stall_level;
      end
   end

   // Watchdog: too long without any beat on any channel ends the run.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         stuck_cycles = 0;
      else
         stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
         $display("Watchdog: no beat for %0d cycles, %0d results still due",
                  stuck_cycles, due_results.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      cfg_width  = 13'd4096;
      cfg_height = 13'd4096;
      cfg_start  = 8'd0;
      begin_frame();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_token_basics();
      test_random_default();
      test_small_image();
      test_dimension_extremes();
      test_backpressure();
      test_random_mixed();
      settle_block();
      $display("Sent %0d beats over %0d frames across several image sizes and colors.",
               beats_sent, frames_started);
      $display("Checked %0d runs, %0d aborts and %0d terminators; %0d mismatches.",
               runs_checked, aborts_checked, ends_checked, check_errors);
      if (check_errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

@@ filelist.f @@
src/sxd_pkg.sv
src/sxd_front.sv
src/sxd_queue.sv
src/sxd_back.sv
src/sixel_stream_run_decoder.sv
test/tb_top.sv
